FILE: hw/rtl/steer_and_drive_ramp_sim_assert.svh
// Assertion macros for the steering and wheel ramp block.
// Each macro expects clk and arst_n in the scope of use.
`ifndef STEER_AND_DRIVE_RAMP_SIM_ASSERT_SVH
`define STEER_AND_DRIVE_RAMP_SIM_ASSERT_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define SDR_ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("sdr assertion failed");
// next-cycle implication
`define SDR_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("sdr assertion failed");
`else
`define SDR_ASSERT_SAME(label, ante, cons)
`define SDR_ASSERT_NEXT(label, ante, cons)
`endif
`endif

FILE: hw/rtl/sdr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package sdr_pkg;

	// default wheel count
	localparam int REAR_WHEELS_DEF = 2;

	// configuration port
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 23;

	localparam logic [CFG_IDX_W-1:0] CFG_SPEED_LIMIT = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_ACCEL_LIMIT = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_STEER_MIN   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_STEER_MAX   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_STEER_RATE  = 3'd4;

	// register reset values
	localparam logic [22:0]        SPEED_LIMIT_RST = 23'd2470700;
	localparam logic [19:0]        ACCEL_LIMIT_RST = 20'd48255;
	localparam logic signed [19:0] STEER_MIN_RST   = -20'sd39322;
	localparam logic signed [19:0] STEER_MAX_RST   = 20'sd39322;
	localparam logic [15:0]        STEER_RATE_RST  = 16'd15360;

	typedef enum logic [1:0] {
		CMD_WRITE    = 2'd0,
		CMD_TICK     = 2'd1,
		CMD_ACTIVATE = 2'd2,
		CMD_STOP     = 2'd3
	} cmd_t;

	typedef struct packed {
		cmd_t               command;
		logic signed [19:0] steer_cmd_left;
		logic signed [19:0] steer_cmd_right;
		logic signed [23:0] wheel_cmd_left;
		logic signed [23:0] wheel_cmd_right;
		logic [15:0]        tick_period;
	} in_item_t;

	typedef struct packed {
		logic signed [19:0] steer_angle;
		logic signed [31:0] wheel_pos_left;
		logic signed [31:0] wheel_pos_right;
		logic signed [23:0] wheel_vel_left;
		logic signed [23:0] wheel_vel_right;
		logic               is_active;
	} out_item_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DECODE,
		ST_RATE,
		ST_VEL,
		ST_POS,
		ST_ACC,
		ST_STEER,
		ST_OUT
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic latch_item;
		logic apply_cmd;
		logic calc_rate;
		logic wheel_vel;
		logic wheel_mult;
		logic wheel_acc;
		logic steer_step;
		logic load_out;
	} ctrl_cmd_t;

	// datapath to controller
	typedef struct packed {
		cmd_t command;
		logic active;
		logic last_wheel;
		logic out_free;
	} dp_status_t;

endpackage
`default_nettype wire

FILE: hw/rtl/sdr_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
module sdr_ctrl (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire sdr_pkg::dp_status_t status,
	output sdr_pkg::ctrl_cmd_t      ctrl
);

	sdr_pkg::state_t state_q, state_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sdr_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			sdr_pkg::ST_IDLE: begin
				if (in_valid) state_d = sdr_pkg::ST_DECODE;
			end
			sdr_pkg::ST_DECODE: begin
				if (status.command == sdr_pkg::CMD_TICK && status.active)
					state_d = sdr_pkg::ST_RATE;
				else
					state_d = sdr_pkg::ST_OUT;
			end
			sdr_pkg::ST_RATE:  state_d = sdr_pkg::ST_VEL;
			sdr_pkg::ST_VEL:   state_d = sdr_pkg::ST_POS;
			sdr_pkg::ST_POS:   state_d = sdr_pkg::ST_ACC;
			sdr_pkg::ST_ACC: begin
				state_d = status.last_wheel ? sdr_pkg::ST_STEER : sdr_pkg::ST_VEL;
			end
			sdr_pkg::ST_STEER: state_d = sdr_pkg::ST_OUT;
			sdr_pkg::ST_OUT: begin
				if (status.out_free) state_d = sdr_pkg::ST_IDLE;
			end
			default: state_d = sdr_pkg::ST_IDLE;
		endcase
	end

	// command outputs
	always_comb begin
		ctrl     = '0;
		in_stall = 1'b1;
		case (state_q)
			sdr_pkg::ST_IDLE: begin
				in_stall        = 1'b0;
				ctrl.latch_item = in_valid;
			end
			sdr_pkg::ST_DECODE: ctrl.apply_cmd  = 1'b1;
			sdr_pkg::ST_RATE:   ctrl.calc_rate  = 1'b1;
			sdr_pkg::ST_VEL:    ctrl.wheel_vel  = 1'b1;
			sdr_pkg::ST_POS:    ctrl.wheel_mult = 1'b1;
			sdr_pkg::ST_ACC:    ctrl.wheel_acc  = 1'b1;
			sdr_pkg::ST_STEER:  ctrl.steer_step = 1'b1;
			sdr_pkg::ST_OUT:    ctrl.load_out   = status.out_free;
			default: ;
		endcase
	end

endmodule
`default_nettype wire

FILE: hw/rtl/sdr_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
module sdr_datapath #(
	parameter int REAR_WHEELS = sdr_pkg::REAR_WHEELS_DEF
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire sdr_pkg::in_item_t              in_data,
	input  wire logic                           cfg_we,
	input  wire logic [sdr_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [sdr_pkg::CFG_DATA_W-1:0] cfg_data,
	input  wire sdr_pkg::ctrl_cmd_t             ctrl,
	output sdr_pkg::dp_status_t                 status,
	output logic                                out_valid,
	input  wire logic                           out_stall,
	output sdr_pkg::out_item_t                  out_data
);

	localparam int IDX_W = (REAR_WHEELS > 1) ? $clog2(REAR_WHEELS) : 1;
	localparam int RI    = (REAR_WHEELS > 1) ? 1 : 0;

	// configuration registers
	logic [22:0]        speed_limit_q;
	logic [19:0]        accel_limit_q;
	logic signed [19:0] steer_min_q;
	logic signed [19:0] steer_max_q;
	logic [15:0]        steer_rate_q;

	// latched item and tick intermediates
	sdr_pkg::in_item_t  item_q;
	logic [27:0]        dv_q;
	logic [23:0]        ds_q;
	logic signed [24:0] sum_q;
	logic signed [41:0] prod_q;
	logic [IDX_W-1:0]   idx_q;

	// model state
	logic               active_q;
	logic signed [19:0] steer_tgt_q;
	logic signed [19:0] steer_pos_q;
	logic signed [23:0] wheel_tgt_q [REAR_WHEELS];
	logic signed [23:0] wheel_vel_q [REAR_WHEELS];
	logic [31:0]        wheel_pos_q [REAR_WHEELS];

	logic               out_valid_q;
	sdr_pkg::out_item_t out_q;

	// clamp a speed to +/- limit
	function automatic logic signed [23:0] clamp_speed(input logic signed [23:0] v,
		input logic [22:0] lim);
		logic signed [24:0] lp;
		logic signed [24:0] ln;
		logic signed [24:0] c;
		lp = {2'b00, lim};
		ln = -lp;
		c  = {v[23], v};
		if (c < ln) c = ln;
		if (c > lp) c = lp;
		return c[23:0];
	endfunction

	// steering target from the mean of both commands, clamped to the steering range
	logic signed [20:0] steer_sum;
	logic signed [19:0] steer_mean;
	logic signed [19:0] steer_clamped;
	always_comb begin
		steer_sum  = {item_q.steer_cmd_left[19], item_q.steer_cmd_left}
			+ {item_q.steer_cmd_right[19], item_q.steer_cmd_right};
		steer_mean = steer_sum[20:1];
		steer_clamped = steer_mean;
		if (steer_clamped < steer_min_q) steer_clamped = steer_min_q;
		if (steer_clamped > steer_max_q) steer_clamped = steer_max_q;
	end

	// per-tick limits
	logic [35:0] dv_prod;
	logic [31:0] ds_prod;
	assign dv_prod = 36'(accel_limit_q) * 36'(item_q.tick_period);
	assign ds_prod = 32'(steer_rate_q) * 32'(item_q.tick_period);

	// velocity step of the selected wheel
	logic signed [23:0] old_vel;
	logic signed [23:0] tgt_lim;
	logic signed [28:0] vdiff;
	logic signed [28:0] dv_p;
	logic signed [28:0] vstep;
	logic signed [24:0] nv_wide;
	logic signed [23:0] new_vel;
	logic signed [24:0] vel_sum;
	always_comb begin
		old_vel = wheel_vel_q[idx_q];
		tgt_lim = clamp_speed(wheel_tgt_q[idx_q], speed_limit_q);
		vdiff   = {{5{tgt_lim[23]}}, tgt_lim} - {{5{old_vel[23]}}, old_vel};
		dv_p    = {1'b0, dv_q};
		vstep   = vdiff;
		if (vstep > dv_p) vstep = dv_p;
		if (vstep < -dv_p) vstep = -dv_p;
		nv_wide = {old_vel[23], old_vel} + vstep[24:0];
		new_vel = nv_wide[23:0];
		vel_sum = {old_vel[23], old_vel} + {new_vel[23], new_vel};
	end

	// trapezoid area times period
	logic signed [16:0] period_s;
	logic signed [41:0] area_prod;
	logic [31:0]        pos_inc;
	assign period_s  = {1'b0, item_q.tick_period};
	assign area_prod = 42'(sum_q) * 42'(period_s);
	assign pos_inc   = {{7{prod_q[41]}}, prod_q[41:17]};

	// steering slew
	logic signed [20:0] sdiff;
	logic signed [24:0] sdiff_w;
	logic signed [24:0] ds_p;
	logic signed [24:0] sstep;
	always_comb begin
		sdiff   = {steer_tgt_q[19], steer_tgt_q} - {steer_pos_q[19], steer_pos_q};
		sdiff_w = {{4{sdiff[20]}}, sdiff};
		ds_p    = {1'b0, ds_q};
		sstep   = sdiff_w;
		if (sstep > ds_p) sstep = ds_p;
		if (sstep < -ds_p) sstep = -ds_p;
	end

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			speed_limit_q <= sdr_pkg::SPEED_LIMIT_RST;
			accel_limit_q <= sdr_pkg::ACCEL_LIMIT_RST;
			steer_min_q   <= sdr_pkg::STEER_MIN_RST;
			steer_max_q   <= sdr_pkg::STEER_MAX_RST;
			steer_rate_q  <= sdr_pkg::STEER_RATE_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				sdr_pkg::CFG_SPEED_LIMIT: speed_limit_q <= cfg_data;
				sdr_pkg::CFG_ACCEL_LIMIT: accel_limit_q <= cfg_data[19:0];
				sdr_pkg::CFG_STEER_MIN:   steer_min_q   <= cfg_data[19:0];
				sdr_pkg::CFG_STEER_MAX:   steer_max_q   <= cfg_data[19:0];
				sdr_pkg::CFG_STEER_RATE:  steer_rate_q  <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	// item latch and tick intermediates
	always_ff @(posedge clk) begin
		if (ctrl.latch_item) item_q <= in_data;
		if (ctrl.calc_rate) begin
			dv_q <= dv_prod[35:8];
			ds_q <= ds_prod[31:8];
		end
		if (ctrl.wheel_vel)  sum_q  <= vel_sum;
		if (ctrl.wheel_mult) prod_q <= area_prod;
	end

	// wheel index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
		end else if (ctrl.calc_rate) begin
			idx_q <= '0;
		end else if (ctrl.wheel_acc && !status.last_wheel) begin
			idx_q <= idx_q + IDX_W'(1);
		end
	end

	// active flag and steering state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q    <= 1'b0;
			steer_tgt_q <= '0;
			steer_pos_q <= '0;
		end else begin
			if (ctrl.apply_cmd) begin
				case (item_q.command)
					sdr_pkg::CMD_WRITE: begin
						if (active_q) steer_tgt_q <= steer_clamped;
					end
					sdr_pkg::CMD_ACTIVATE: begin
						steer_tgt_q <= steer_pos_q;
						active_q    <= 1'b1;
					end
					sdr_pkg::CMD_STOP: begin
						steer_tgt_q <= steer_pos_q;
						active_q    <= 1'b0;
					end
					default: ;
				endcase
			end
			if (ctrl.steer_step) steer_pos_q <= steer_pos_q + sstep[19:0];
		end
	end

	// wheel state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < REAR_WHEELS; i++) begin
				wheel_tgt_q[i] <= '0;
				wheel_vel_q[i] <= '0;
				wheel_pos_q[i] <= '0;
			end
		end else begin
			for (int i = 0; i < REAR_WHEELS; i++) begin
				if (ctrl.apply_cmd) begin
					case (item_q.command)
						sdr_pkg::CMD_WRITE: begin
							if (active_q) begin
								wheel_tgt_q[i] <= clamp_speed((i % 2 == 1) ?
									item_q.wheel_cmd_right : item_q.wheel_cmd_left,
									speed_limit_q);
							end
						end
						sdr_pkg::CMD_ACTIVATE, sdr_pkg::CMD_STOP: begin
							wheel_tgt_q[i] <= '0;
							wheel_vel_q[i] <= '0;
						end
						default: ;
					endcase
				end
				if (ctrl.wheel_vel && idx_q == IDX_W'(i)) wheel_vel_q[i] <= new_vel;
				if (ctrl.wheel_acc && idx_q == IDX_W'(i))
					wheel_pos_q[i] <= wheel_pos_q[i] + pos_inc;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctrl.load_out) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.load_out) begin
			out_q.steer_angle     <= steer_pos_q;
			out_q.wheel_pos_left  <= wheel_pos_q[0];
			out_q.wheel_pos_right <= wheel_pos_q[RI];
			out_q.wheel_vel_left  <= wheel_vel_q[0];
			out_q.wheel_vel_right <= wheel_vel_q[RI];
			out_q.is_active       <= active_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// status to controller
	assign status.command    = item_q.command;
	assign status.active     = active_q;
	assign status.last_wheel = (idx_q == IDX_W'(REAR_WHEELS - 1));
	assign status.out_free   = !out_valid_q || !out_stall;

endmodule
`default_nettype wire

FILE: hw/rtl/steer_and_drive_ramp_sim.sv
// A write, activate or stop item, or an inactive tick, is decoded and loaded into the output
// register; an active tick first runs the rate step, the steps of each wheel and the steering
// step. One item at a time: the next is taken only once the result is loaded, which waits
// for any output stall. Each wheel takes three steps: velocity through one shared clamp,
// area through one shared multiplier, and a position add into its own register.
// Reset (arst_n, async low): idle, inactive, all motion state zero, limits at defaults.
`timescale 1ns / 1ps
`default_nettype none
`include "steer_and_drive_ramp_sim_assert.svh"
module steer_and_drive_ramp_sim #(
	parameter int REAR_WHEELS = sdr_pkg::REAR_WHEELS_DEF
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           in_valid,
	output logic                                in_stall,
	input  wire sdr_pkg::in_item_t              in_data,
	output logic                                out_valid,
	input  wire logic                           out_stall,
	output sdr_pkg::out_item_t                  out_data,
	input  wire logic                           cfg_we,
	input  wire logic [sdr_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [sdr_pkg::CFG_DATA_W-1:0] cfg_data
);

	sdr_pkg::ctrl_cmd_t  ctrl;
	sdr_pkg::dp_status_t status;

	sdr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.status   (status),
		.ctrl     (ctrl)
	);

	sdr_datapath #(
		.REAR_WHEELS (REAR_WHEELS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_data   (in_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.ctrl      (ctrl),
		.status    (status),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

	// a transaction keeps the block busy on the next cycle
	`SDR_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall)
	// a result is never loaded over one that is still waiting
	`SDR_ASSERT_SAME(a_load_when_free, ctrl.load_out, !out_valid || !out_stall)
	// nothing is loaded while the block waits for input
	`SDR_ASSERT_SAME(a_no_load_idle, !in_stall, !ctrl.load_out)
	// after a load the output shows a result
	`SDR_ASSERT_NEXT(a_valid_after_load, ctrl.load_out, out_valid)

endmodule
`default_nettype wire
